### rtl/core/bss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bss_pkg;

    // Sensor sample word
    typedef struct packed {
        logic       manual_pressed;
        logic       checker_pressed;
        logic [7:0] distance_cm;
        logic [2:0] color_code;
    } sample_t;

    // Result word
    typedef struct packed {
        logic              started;
        logic              motor_run;
        logic              motor_halt;
        logic signed [7:0] drive_power;
        logic [1:0]        led_cmd;
        logic [2:0]        block_phase;
        logic [2:0]        display_phase;
        logic [1:0]        rotor_phase;
        logic [1:0]        aspect;
    } result_t;

    // Configuration registers as seen by the sequencer
    typedef struct packed {
        logic [7:0]        detect_threshold;
        logic signed [7:0] motor_power;
    } cfg_t;

    localparam logic [7:0] RESET_THRESHOLD = 8'd10;
    localparam logic [7:0] RESET_POWER     = 8'd10;

    // Register indexes
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_POWER     = 1'b1;

    // Color codes; only blue, green, yellow and red get latched
    localparam logic [2:0] COL_NONE   = 3'd0;
    localparam logic [2:0] COL_BLACK  = 3'd1;
    localparam logic [2:0] COL_BLUE   = 3'd2;
    localparam logic [2:0] COL_GREEN  = 3'd3;
    localparam logic [2:0] COL_YELLOW = 3'd4;
    localparam logic [2:0] COL_RED    = 3'd5;
    localparam logic [2:0] COL_WHITE  = 3'd6;
    localparam logic [2:0] COL_BROWN  = 3'd7;

    localparam logic [1:0] LED_NONE  = 2'd0;
    localparam logic [1:0] LED_AMBER = 2'd1;
    localparam logic [1:0] LED_RED   = 2'd2;
    localparam logic [1:0] LED_GO    = 2'd3;

    localparam logic OP_STOP = 1'b0;
    localparam logic OP_DEP  = 1'b1;

    localparam logic [1:0] ASPECT_NONE = 2'd0;
    localparam logic [1:0] ASPECT_STOP = 2'd1;
    localparam logic [1:0] ASPECT_DEP  = 2'd2;

    // Phase codes reported on the result word
    localparam logic [2:0] BPH_INIT    = 3'd0;
    localparam logic [2:0] BPH_TO_STOP = 3'd1;
    localparam logic [2:0] BPH_STOPPED = 3'd2;
    localparam logic [2:0] BPH_TO_DEP  = 3'd3;
    localparam logic [2:0] BPH_DEP     = 3'd4;

    localparam logic [2:0] DPH_INIT      = 3'd0;
    localparam logic [2:0] DPH_WAIT_STOP = 3'd1;
    localparam logic [2:0] DPH_STOP      = 3'd2;
    localparam logic [2:0] DPH_WAIT_DEP  = 3'd3;
    localparam logic [2:0] DPH_DEP       = 3'd4;

    localparam logic [1:0] RPH_INIT    = 2'd0;
    localparam logic [1:0] RPH_CHK_OFF = 2'd1;
    localparam logic [1:0] RPH_CHK_ON  = 2'd2;
    localparam logic [1:0] RPH_STOPPED = 2'd3;

    typedef enum logic [4:0] {
        BLK_INIT    = 5'b00001,
        BLK_TO_STOP = 5'b00010,
        BLK_STOPPED = 5'b00100,
        BLK_TO_DEP  = 5'b01000,
        BLK_DEP     = 5'b10000
    } blk_state_t;

    typedef enum logic [4:0] {
        DSP_INIT      = 5'b00001,
        DSP_WAIT_STOP = 5'b00010,
        DSP_STOP      = 5'b00100,
        DSP_WAIT_DEP  = 5'b01000,
        DSP_DEP       = 5'b10000
    } dsp_state_t;

    typedef enum logic [3:0] {
        ROT_INIT    = 4'b0001,
        ROT_CHK_OFF = 4'b0010,
        ROT_CHK_ON  = 4'b0100,
        ROT_STOPPED = 4'b1000
    } rot_state_t;

    function automatic logic [2:0] blk_phase(input blk_state_t s);
        logic [2:0] p;
        p = BPH_INIT;
        unique case (s)
            BLK_INIT:    p = BPH_INIT;
            BLK_TO_STOP: p = BPH_TO_STOP;
            BLK_STOPPED: p = BPH_STOPPED;
            BLK_TO_DEP:  p = BPH_TO_DEP;
            BLK_DEP:     p = BPH_DEP;
            default:     p = BPH_INIT;
        endcase
        return p;
    endfunction

    function automatic logic [2:0] dsp_phase(input dsp_state_t s);
        logic [2:0] p;
        p = DPH_INIT;
        unique case (s)
            DSP_INIT:      p = DPH_INIT;
            DSP_WAIT_STOP: p = DPH_WAIT_STOP;
            DSP_STOP:      p = DPH_STOP;
            DSP_WAIT_DEP:  p = DPH_WAIT_DEP;
            DSP_DEP:       p = DPH_DEP;
            default:       p = DPH_INIT;
        endcase
        return p;
    endfunction

    function automatic logic [1:0] rot_phase(input rot_state_t s);
        logic [1:0] p;
        p = RPH_INIT;
        unique case (s)
            ROT_INIT:    p = RPH_INIT;
            ROT_CHK_OFF: p = RPH_CHK_OFF;
            ROT_CHK_ON:  p = RPH_CHK_ON;
            ROT_STOPPED: p = RPH_STOPPED;
            default:     p = RPH_INIT;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

### rtl/core/bss_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module bss_cfg
    import bss_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output cfg_t             cfg
);

    logic [7:0] threshold_reg;
    logic [7:0] power_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Keep the low byte of the written data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= RESET_THRESHOLD;
            power_reg     <= RESET_POWER;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_THRESHOLD: threshold_reg <= pwdata[7:0];
                REG_POWER:     power_reg     <= pwdata[7:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_THRESHOLD: prdata = {24'd0, threshold_reg};
            REG_POWER:     prdata = {24'd0, power_reg};
            default:       prdata = '0;
        endcase
    end

    assign cfg.detect_threshold = threshold_reg;
    assign cfg.motor_power      = power_reg;

endmodule

`default_nettype wire

### rtl/core/bss_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module bss_seq
    import bss_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    fire,
    input  wire sample_t sample,
    input  wire cfg_t    cfg,
    output result_t      result
);

    logic       init_done_reg, init_done_next;
    blk_state_t blk_reg, blk_next;
    logic       blk_entry_reg, blk_entry_next;
    dsp_state_t dsp_reg, dsp_next;
    logic       dsp_entry_reg, dsp_entry_next;
    rot_state_t rot_reg, rot_next;
    logic       rot_entry_reg, rot_entry_next;
    logic       rotate_req_reg, rotate_req_next;
    logic       op_req_reg, op_req_next;
    logic [2:0] color_reg, color_next;

    logic       run;
    logic       halt;
    logic [1:0] led;
    logic       rotor_done;

    always_comb
    begin
        init_done_next  = init_done_reg;
        blk_next        = blk_reg;
        blk_entry_next  = blk_entry_reg;
        dsp_next        = dsp_reg;
        dsp_entry_next  = dsp_entry_reg;
        rot_next        = rot_reg;
        rot_entry_next  = rot_entry_reg;
        rotate_req_next = rotate_req_reg;
        op_req_next     = op_req_reg;
        color_next      = color_reg;
        run             = 1'b0;
        halt            = 1'b0;
        led             = LED_NONE;
        rotor_done      = (rot_reg == ROT_STOPPED);

        if (!init_done_reg)
        begin
            // Hold every machine until the track reads clear
            if (sample.distance_cm > cfg.detect_threshold)
                init_done_next = 1'b1;
        end
        else
        begin
            // Block machine: sees the color latched on earlier words
            unique case (blk_reg)
                BLK_INIT:
                begin
                    blk_next       = BLK_TO_STOP;
                    blk_entry_next = 1'b1;
                end
                BLK_TO_STOP:
                begin
                    if (blk_entry_reg)
                    begin
                        blk_entry_next = 1'b0;
                        op_req_next    = OP_STOP;
                    end
                    if (color_reg == COL_RED)
                    begin
                        blk_next       = BLK_STOPPED;
                        blk_entry_next = 1'b1;
                    end
                end
                BLK_STOPPED:
                begin
                    blk_entry_next = 1'b0;
                    if (sample.manual_pressed)
                    begin
                        blk_next       = BLK_TO_DEP;
                        blk_entry_next = 1'b1;
                    end
                end
                BLK_TO_DEP:
                begin
                    if (blk_entry_reg)
                    begin
                        blk_entry_next = 1'b0;
                        op_req_next    = OP_DEP;
                    end
                    if (color_reg == COL_GREEN)
                    begin
                        blk_next       = BLK_DEP;
                        blk_entry_next = 1'b1;
                    end
                end
                BLK_DEP:
                begin
                    blk_entry_next = 1'b0;
                    if (sample.manual_pressed
                        || (sample.distance_cm < cfg.detect_threshold))
                    begin
                        blk_next       = BLK_TO_STOP;
                        blk_entry_next = 1'b1;
                    end
                end
                default: ;
            endcase

            // Latch only the four signal colors
            if (sample.color_code inside {COL_RED, COL_GREEN, COL_BLUE, COL_YELLOW})
                color_next = sample.color_code;

            // Display machine: rotor test comes last and wins
            unique case (dsp_reg)
                DSP_INIT:
                begin
                    if (dsp_entry_reg)
                        op_req_next = OP_STOP;
                    dsp_next       = DSP_WAIT_STOP;
                    dsp_entry_next = 1'b1;
                end
                DSP_WAIT_STOP:
                begin
                    if (dsp_entry_reg)
                    begin
                        dsp_entry_next  = 1'b0;
                        rotate_req_next = 1'b1;
                        led             = LED_AMBER;
                    end
                    if (op_req_next == OP_DEP)
                    begin
                        dsp_next       = DSP_WAIT_DEP;
                        dsp_entry_next = 1'b1;
                    end
                    if (rotor_done)
                    begin
                        dsp_next       = (color_next == COL_RED) ? DSP_STOP : DSP_WAIT_STOP;
                        dsp_entry_next = 1'b1;
                    end
                end
                DSP_STOP:
                begin
                    if (dsp_entry_reg)
                    begin
                        dsp_entry_next  = 1'b0;
                        rotate_req_next = 1'b0;
                        led             = LED_RED;
                    end
                    if (op_req_next == OP_DEP)
                    begin
                        dsp_next       = DSP_WAIT_DEP;
                        dsp_entry_next = 1'b1;
                    end
                end
                DSP_WAIT_DEP:
                begin
                    if (dsp_entry_reg)
                    begin
                        dsp_entry_next  = 1'b0;
                        rotate_req_next = 1'b1;
                        led             = LED_AMBER;
                    end
                    if (op_req_next == OP_STOP)
                    begin
                        dsp_next       = DSP_WAIT_STOP;
                        dsp_entry_next = 1'b1;
                    end
                    if (rotor_done)
                    begin
                        dsp_next       = (color_next == COL_GREEN) ? DSP_DEP : DSP_WAIT_DEP;
                        dsp_entry_next = 1'b1;
                    end
                end
                DSP_DEP:
                begin
                    if (dsp_entry_reg)
                    begin
                        dsp_entry_next  = 1'b0;
                        rotate_req_next = 1'b0;
                        led             = LED_GO;
                    end
                    if (op_req_next == OP_STOP)
                    begin
                        dsp_next       = DSP_WAIT_STOP;
                        dsp_entry_next = 1'b1;
                    end
                end
                default: ;
            endcase

            // Rotator machine: run until checker pressed then released
            unique case (rot_reg)
                ROT_INIT:
                begin
                    if (rot_entry_reg)
                        rotate_req_next = 1'b0;
                    rot_next       = ROT_CHK_OFF;
                    rot_entry_next = 1'b1;
                end
                ROT_CHK_OFF:
                begin
                    if (rot_entry_reg)
                    begin
                        rot_entry_next  = 1'b0;
                        rotate_req_next = 1'b1;
                        run             = 1'b1;
                    end
                    if (sample.checker_pressed)
                    begin
                        rot_next       = ROT_CHK_ON;
                        rot_entry_next = 1'b1;
                    end
                end
                ROT_CHK_ON:
                begin
                    if (rot_entry_reg)
                    begin
                        rot_entry_next  = 1'b0;
                        rotate_req_next = 1'b1;
                        run             = 1'b1;
                    end
                    if (!sample.checker_pressed)
                    begin
                        rot_next       = ROT_STOPPED;
                        rot_entry_next = 1'b1;
                        halt           = 1'b1;
                    end
                end
                ROT_STOPPED:
                begin
                    if (rot_entry_reg)
                    begin
                        rot_entry_next  = 1'b0;
                        rotate_req_next = 1'b0;
                    end
                    else if (rotate_req_next)
                    begin
                        rot_next       = ROT_CHK_OFF;
                        rot_entry_next = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_done_reg  <= 1'b0;
            blk_reg        <= BLK_INIT;
            blk_entry_reg  <= 1'b1;
            dsp_reg        <= DSP_INIT;
            dsp_entry_reg  <= 1'b1;
            rot_reg        <= ROT_INIT;
            rot_entry_reg  <= 1'b1;
            rotate_req_reg <= 1'b0;
            op_req_reg     <= OP_STOP;
            color_reg      <= COL_NONE;
        end
        else if (fire)
        begin
            init_done_reg  <= init_done_next;
            blk_reg        <= blk_next;
            blk_entry_reg  <= blk_entry_next;
            dsp_reg        <= dsp_next;
            dsp_entry_reg  <= dsp_entry_next;
            rot_reg        <= rot_next;
            rot_entry_reg  <= rot_entry_next;
            rotate_req_reg <= rotate_req_next;
            op_req_reg     <= op_req_next;
            color_reg      <= color_next;
        end
    end

    always_comb
    begin
        result.started       = init_done_next;
        result.motor_run     = run;
        result.motor_halt    = halt;
        result.drive_power   = run ? cfg.motor_power : '0;
        result.led_cmd       = led;
        result.block_phase   = blk_phase(blk_next);
        result.display_phase = dsp_phase(dsp_next);
        result.rotor_phase   = rot_phase(rot_next);
        if (color_next == COL_RED)
            result.aspect = ASPECT_STOP;
        else if (color_next == COL_GREEN)
            result.aspect = ASPECT_DEP;
        else
            result.aspect = ASPECT_NONE;
    end

endmodule

`default_nettype wire

### rtl/core/block_signal_sequencer_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Dir | Handshake                       | Word
// ---------+-----+---------------------------------+---------------------------------
// sample   | in  | sample_valid / sample_ready     | sample_t: switches, distance, color
// result   | out | result_valid / result_ready     | result_t: motor, LED, phases, aspect
// config   | in  | APB psel/penable/pwrite, paddr  | threshold at 0x0, motor power at 0x4
//
// A sample word is first held in the input register; when it fires, the machines
// advance and the result register loads at the same edge, and one word per cycle
// flows while result_ready is high. A result stall holds both registers; the input
// register still takes one word while the result waits. Reset puts every machine in
// init with entry actions pending and the configuration at threshold 10, power 10.

module block_signal_sequencer_unit
    import bss_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        sample_valid,
    output logic             sample_ready,
    input  wire sample_t     sample,

    output logic             result_valid,
    input  wire logic        result_ready,
    output result_t          result,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    cfg_t    cfg;
    sample_t sample_reg;
    logic    sample_valid_reg;
    result_t result_reg;
    logic    result_valid_reg;
    result_t step_result;
    logic    fire;

    bss_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Advance the held word whenever the result register is empty or draining
    assign fire         = sample_valid_reg && (!result_valid_reg || result_ready);
    assign sample_ready = !sample_valid_reg || fire;

    bss_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .sample (sample_reg),
        .cfg    (cfg),
        .result (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid_reg <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample_ready)
                sample_valid_reg <= sample_valid;
            if (fire)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    // Payload registers: no reset, load on handshake only
    always_ff @(posedge clk)
    begin
        if (sample_ready && sample_valid)
            sample_reg <= sample;
        if (fire)
            result_reg <= step_result;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

### tb/sequencer_checker.sv
`timescale 1ns / 1ps

module sequencer_checker
    import bss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_valid,
    input  logic        sample_ready,
    input  sample_t     sample,
    input  logic        result_valid,
    input  logic        result_ready,
    input  result_t     result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending,
    output int          words_checked
);

    // Predicted sequencer state
    cfg_t       cfg;
    logic       started_q;
    logic [2:0] blk_phase_q;
    logic       blk_entry;
    logic [2:0] dsp_phase_q;
    logic       dsp_entry;
    logic [1:0] rot_phase_q;
    logic       rot_entry;
    logic       rotate_req;
    logic       op_req;
    logic [2:0] latched;

    result_t    expected_results[$];
    result_t    want;
    string      diff;

    // Advance the predicted machines by one sensor word and return the result word.
    function automatic result_t step_sequencer(input sample_t s);
        result_t    r;
        logic       run;
        logic       halt;
        logic       detected;
        logic       rotor_done;
        logic [1:0] led;
        run  = 1'b0;
        halt = 1'b0;
        led  = LED_NONE;
        if (!started_q) begin
            if (s.distance_cm > cfg.detect_threshold)
                started_q = 1'b1;
        end
        else begin
            detected = s.distance_cm < cfg.detect_threshold;
            case (blk_phase_q)
                BPH_INIT: begin
                    blk_phase_q = BPH_TO_STOP;
                    blk_entry   = 1'b1;
                end
                BPH_TO_STOP: begin
                    if (blk_entry) begin
                        blk_entry = 1'b0;
                        op_req    = OP_STOP;
                    end
                    if (latched == COL_RED) begin
                        blk_phase_q = BPH_STOPPED;
                        blk_entry   = 1'b1;
                    end
                end
                BPH_STOPPED: begin
                    blk_entry = 1'b0;
                    if (s.manual_pressed) begin
                        blk_phase_q = BPH_TO_DEP;
                        blk_entry   = 1'b1;
                    end
                end
                BPH_TO_DEP: begin
                    if (blk_entry) begin
                        blk_entry = 1'b0;
                        op_req    = OP_DEP;
                    end
                    if (latched == COL_GREEN) begin
                        blk_phase_q = BPH_DEP;
                        blk_entry   = 1'b1;
                    end
                end
                BPH_DEP: begin
                    blk_entry = 1'b0;
                    if (s.manual_pressed || detected) begin
                        blk_phase_q = BPH_TO_STOP;
                        blk_entry   = 1'b1;
                    end
                end
                default: ;
            endcase

            if (s.color_code == COL_RED || s.color_code == COL_GREEN ||
                s.color_code == COL_BLUE || s.color_code == COL_YELLOW)
                latched = s.color_code;

            // Display looks at the rotor phase left by the previous word
            rotor_done = (rot_phase_q == RPH_STOPPED);
            case (dsp_phase_q)
                DPH_INIT: begin
                    if (dsp_entry) begin
                        dsp_entry = 1'b0;
                        op_req    = OP_STOP;
                    end
                    dsp_phase_q = DPH_WAIT_STOP;
                    dsp_entry   = 1'b1;
                end
                DPH_WAIT_STOP: begin
                    if (dsp_entry) begin
                        dsp_entry  = 1'b0;
                        rotate_req = 1'b1;
                        led        = LED_AMBER;
                    end
                    if (op_req == OP_DEP) begin
                        dsp_phase_q = DPH_WAIT_DEP;
                        dsp_entry   = 1'b1;
                    end
                    if (rotor_done) begin
                        dsp_phase_q = (latched == COL_RED) ? DPH_STOP : DPH_WAIT_STOP;
                        dsp_entry   = 1'b1;
                    end
                end
                DPH_STOP: begin
                    if (dsp_entry) begin
                        dsp_entry  = 1'b0;
                        rotate_req = 1'b0;
                        led        = LED_RED;
                    end
                    if (op_req == OP_DEP) begin
                        dsp_phase_q = DPH_WAIT_DEP;
                        dsp_entry   = 1'b1;
                    end
                end
                DPH_WAIT_DEP: begin
                    if (dsp_entry) begin
                        dsp_entry  = 1'b0;
                        rotate_req = 1'b1;
                        led        = LED_AMBER;
                    end
                    if (op_req == OP_STOP) begin
                        dsp_phase_q = DPH_WAIT_STOP;
                        dsp_entry   = 1'b1;
                    end
                    if (rotor_done) begin
                        dsp_phase_q = (latched == COL_GREEN) ? DPH_DEP : DPH_WAIT_DEP;
                        dsp_entry   = 1'b1;
                    end
                end
                DPH_DEP: begin
                    if (dsp_entry) begin
                        dsp_entry  = 1'b0;
                        rotate_req = 1'b0;
                        led        = LED_GO;
                    end
                    if (op_req == OP_STOP) begin
                        dsp_phase_q = DPH_WAIT_STOP;
                        dsp_entry   = 1'b1;
                    end
                end
                default: ;
            endcase

            case (rot_phase_q)
                RPH_INIT: begin
                    if (rot_entry) begin
                        rot_entry  = 1'b0;
                        rotate_req = 1'b0;
                    end
                    rot_phase_q = RPH_CHK_OFF;
                    rot_entry   = 1'b1;
                end
                RPH_CHK_OFF: begin
                    if (rot_entry) begin
                        rot_entry  = 1'b0;
                        rotate_req = 1'b1;
                        run        = 1'b1;
                    end
                    if (s.checker_pressed) begin
                        rot_phase_q = RPH_CHK_ON;
                        rot_entry   = 1'b1;
                    end
                end
                RPH_CHK_ON: begin
                    if (rot_entry) begin
                        rot_entry  = 1'b0;
                        rotate_req = 1'b1;
                        run        = 1'b1;
                    end
                    if (!s.checker_pressed) begin
                        rot_phase_q = RPH_STOPPED;
                        rot_entry   = 1'b1;
                    end
                    if (rot_entry)
                        halt = 1'b1;
                end
                default: begin
                    if (rot_entry) begin
                        rot_entry  = 1'b0;
                        rotate_req = 1'b0;
                    end
                    if (rotate_req) begin
                        rot_phase_q = RPH_CHK_OFF;
                        rot_entry   = 1'b1;
                    end
                end
            endcase
        end

        r.started       = started_q;
        r.motor_run     = run;
        r.motor_halt    = halt;
        r.drive_power   = run ? cfg.motor_power : 8'sd0;
        r.led_cmd       = led;
        r.block_phase   = blk_phase_q;
        r.display_phase = dsp_phase_q;
        r.rotor_phase   = rot_phase_q;
        r.aspect        = (latched == COL_RED) ? ASPECT_STOP :
                          (latched == COL_GREEN) ? ASPECT_DEP : ASPECT_NONE;
        return r;
    endfunction

    // One line of field values for a mismatch report
    function automatic string fmt_result(input result_t r);
        return {$sformatf("st=%0d run=%0d halt=%0d pwr=%0d led=%0d ",
                          r.started, r.motor_run, r.motor_halt, r.drive_power, r.led_cmd),
                $sformatf("blk=%0d dsp=%0d rot=%0d asp=%0d",
                          r.block_phase, r.display_phase, r.rotor_phase, r.aspect)};
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg.detect_threshold = RESET_THRESHOLD;
            cfg.motor_power      = RESET_POWER;
            started_q            = 1'b0;
            blk_phase_q          = BPH_INIT;
            blk_entry            = 1'b1;
            dsp_phase_q          = DPH_INIT;
            dsp_entry            = 1'b1;
            rot_phase_q          = RPH_INIT;
            rot_entry            = 1'b1;
            rotate_req           = 1'b0;
            op_req               = OP_STOP;
            latched              = COL_NONE;
            expected_results.delete();
            fail_count           = 0;
            pending              = 0;
            words_checked        = 0;
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == {REG_THRESHOLD, 2'b00})
                    cfg.detect_threshold = pwdata[7:0];
                else if (paddr == {REG_POWER, 2'b00})
                    cfg.motor_power = pwdata[7:0];
            end

            if (sample_valid && sample_ready)
                expected_results.push_back(step_sequencer(sample));

            if (result_valid && result_ready) begin
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result word %h arrived with nothing expected",
                                 $realtime, result);
                end
                else begin
                    want = expected_results.pop_front();
                    diff = "";
                    if (result.started !== want.started)             diff = {diff, " started"};
                    if (result.motor_run !== want.motor_run)         diff = {diff, " motor_run"};
                    if (result.motor_halt !== want.motor_halt)       diff = {diff, " motor_halt"};
                    if (result.drive_power !== want.drive_power)     diff = {diff, " drive_power"};
                    if (result.led_cmd !== want.led_cmd)             diff = {diff, " led_cmd"};
                    if (result.block_phase !== want.block_phase)     diff = {diff, " block_phase"};
                    if (result.display_phase !== want.display_phase) diff = {diff, " display_phase"};
                    if (result.rotor_phase !== want.rotor_phase)     diff = {diff, " rotor_phase"};
                    if (result.aspect !== want.aspect)               diff = {diff, " aspect"};
                    if (diff != "") begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("%0t: result word %0d differs in%s", $realtime,
                                     words_checked, diff);
                            $display("  expected %s", fmt_result(want));
                            $display("  actual   %s", fmt_result(result));
                        end
                    end
                    words_checked++;
                end
            end

            pending = expected_results.size();
        end
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import bss_pkg::*;

    // Abort once this many cycles pass with no word, result or register write moving
    localparam int QUIET_LIMIT = 200;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        sample_valid = 1'b0;
    logic        sample_ready;
    sample_t     sample_word  = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    result_t     result_word;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [2:0]  paddr        = '0;
    logic [31:0] pwdata       = '0;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending;
    int          words_checked;

    int          words_sent    = 0;
    int          config_count  = 0;
    int          quiet_cycles  = 0;
    int          sink_hold     = 0;
    logic        steady        = 1'b0;  // no idling on either side while set
    logic        checker_level = 1'b0;
    int          checker_run   = 0;
    logic [7:0]  cur_threshold = RESET_THRESHOLD;
    int          phase;
    int          n;
    logic signed [7:0] rand_power;

    // 4 ns clock
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    block_signal_sequencer_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample_word),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result_word),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    sequencer_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample_valid  (sample_valid),
        .sample_ready  (sample_ready),
        .sample        (sample_word),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result        (result_word),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .pending       (pending),
        .words_checked (words_checked)
    );

    // Result side: after each accepted result word, draw a random stall length and
    // hold ready low for that long. Draw it at the rising edge, apply it at the
    // falling edge.
    always @(posedge clk) begin
        if (result_valid && result_ready)
            sink_hold = steady ? 0 : $urandom_range(0, 4);
    end

    always @(negedge clk) begin
        if (sink_hold > 0) begin
            result_ready <= 1'b0;
            sink_hold--;
        end
        else begin
            result_ready <= 1'b1;
        end
    end

    // Watchdog: count cycles in which nothing at all is accepted.
    always @(posedge clk) begin
        if (!rst_n || (sample_valid && sample_ready) || (result_valid && result_ready) ||
            (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no handshake for %0d cycles, %0d results still due",
                     QUIET_LIMIT, pending);
            $display("block_signal_sequencer_unit test failed");
            $finish;
        end
    end

    function automatic sample_t word_of(input logic m, input logic c,
                                        input logic [7:0] d, input logic [2:0] col);
        sample_t w;
        w.manual_pressed  = m;
        w.checker_pressed = c;
        w.distance_cm     = d;
        w.color_code      = col;
        return w;
    endfunction

    // Build a random sensor word. Most words look like a real track: the checker
    // switch holds its level for a few words so the rotor sees press and release,
    // red and green show up often, and the distance sits mostly above the
    // threshold with the odd close reading. About one word in ten is pure noise.
    function automatic sample_t random_word();
        sample_t w;
        int      pick;
        if (checker_run == 0) begin
            checker_level = ~checker_level;
            checker_run   = $urandom_range(1, 4);
        end
        checker_run--;
        w.checker_pressed = checker_level;
        w.manual_pressed  = ($urandom_range(0, 99) < 12);

        pick = $urandom_range(0, 99);
        if (pick < 40)
            w.color_code = $urandom_range(0, 1) ? COL_RED : COL_GREEN;
        else if (pick < 55)
            w.color_code = $urandom_range(0, 1) ? COL_BLUE : COL_YELLOW;
        else
            w.color_code = 3'($urandom_range(0, 7));

        pick = $urandom_range(0, 99);
        if (pick < 80 && cur_threshold != 8'd255)
            w.distance_cm = 8'($urandom_range(cur_threshold + 1, 255));
        else if (pick < 92)
            w.distance_cm = 8'($urandom_range(0, cur_threshold));
        else
            w.distance_cm = 8'($urandom_range(0, 255));

        if ($urandom_range(0, 9) == 0)
            w = sample_t'(12'($urandom));
        return w;
    endfunction

    // Offer one sensor word after a random gap; hold valid and payload until taken.
    task automatic send_word(input sample_t w);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        repeat (gap) begin
            @(negedge clk);
            sample_valid <= 1'b0;
        end
        @(negedge clk);
        sample_valid <= 1'b1;
        sample_word  <= w;
        do @(posedge clk); while (!sample_ready);
        words_sent++;
    endtask

    // Drop valid and wait until every predicted result has come back, then let
    // the pipeline go quiet before touching the registers.
    task automatic settle();
        @(negedge clk);
        sample_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input logic [7:0] thr, input logic signed [7:0] pwr);
        write_reg(REG_THRESHOLD, {24'd0, thr});
        write_reg(REG_POWER, {{24{pwr[7]}}, pwr});
        cur_threshold = thr;
        config_count++;
    endtask

    initial begin
        // Hold reset low, then release it at a falling edge.
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Waiting ticks: with the threshold at its top nothing can start the
        // machines, not even the farthest reading or both switches pressed.
        set_config(8'd255, -8'sd100);
        send_word(word_of(1'b0, 1'b0, 8'd0, COL_NONE));
        send_word(word_of(1'b1, 1'b1, 8'd255, COL_BROWN));
        settle();

        set_config(RESET_THRESHOLD, 8'sd100);
        // Distance equal to the threshold still waits; a red seen now is not latched.
        send_word(word_of(1'b0, 1'b0, 8'd10, COL_RED));
        send_word(word_of(1'b0, 1'b0, 8'd11, COL_NONE));           // clear track, start
        // First run of all three machines, latch red
        send_word(word_of(1'b0, 1'b0, 8'd200, COL_RED));
        // Block goes to stopped on red; rotor sees the checker pressed
        send_word(word_of(1'b0, 1'b1, 8'd200, COL_NONE));
        send_word(word_of(1'b0, 1'b0, 8'd200, COL_NONE));          // release: motor halt
        send_word(word_of(1'b0, 1'b0, 8'd200, COL_BLACK));         // black, rotor done
        send_word(word_of(1'b1, 1'b0, 8'd200, COL_GREEN));         // manual: to departure
        send_word(word_of(1'b0, 1'b0, 8'd200, COL_NONE));
        send_word(word_of(1'b0, 1'b0, 8'd200, COL_WHITE));         // white, ignored
        send_word(word_of(1'b0, 1'b1, 8'd200, COL_NONE));
        send_word(word_of(1'b0, 1'b0, 8'd255, COL_YELLOW));
        // Rotor stops with blue latched: block and display stay in departure
        send_word(word_of(1'b0, 1'b0, 8'd255, COL_BLUE));
        send_word(word_of(1'b0, 1'b0, 8'd255, COL_BROWN));         // brown, ignored
        send_word(word_of(1'b0, 1'b1, 8'd255, COL_GREEN));
        send_word(word_of(1'b0, 1'b0, 8'd255, COL_NONE));
        send_word(word_of(1'b0, 1'b0, 8'd255, COL_NONE));
        // Train detected in departure drops the block back to stop
        send_word(word_of(1'b0, 1'b0, 8'd0, COL_NONE));
        send_word(word_of(1'b0, 1'b0, 8'd255, COL_RED));
        send_word(word_of(1'b1, 1'b1, 8'd128, COL_NONE));
        send_word(word_of(1'b1, 1'b0, 8'd9, COL_GREEN));
        send_word(word_of(1'b1, 1'b1, 8'd10, COL_GREEN));
        send_word(word_of(1'b1, 1'b0, 8'd77, COL_RED));
        settle();

        // Random phases, each under its own register setting. The drain before
        // every write is also the sender pausing until all results are in.
        for (phase = 0; phase < 4; phase++) begin
            rand_power = 8'($urandom_range(0, 200) - 100);
            case (phase)
                0: set_config(8'd0, -8'sd100);
                1: set_config(8'd255, 8'sd100);
                2: set_config(8'($urandom_range(0, 255)), rand_power);
                default: set_config(RESET_THRESHOLD, RESET_POWER);
            endcase
            for (n = 0; n < 270; n++) begin
                // Run a stretch at full rate in the middle of every phase
                steady = (n >= 100 && n < 150);
                send_word(random_word());
            end
            steady = 1'b0;
            settle();
        end

        repeat (8) @(posedge clk);
        $display("Summary: %0d sensor words under %0d register settings,",
                 words_sent, config_count);
        $display("  %0d result words compared, %0d mismatches", words_checked, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("block_signal_sequencer_unit test passed");
        else
            $display("block_signal_sequencer_unit test failed");
        $finish;
    end

endmodule

### filelist.f
rtl/core/bss_pkg.sv
rtl/core/bss_cfg.sv
rtl/core/bss_seq.sv
rtl/core/block_signal_sequencer_unit.sv
tb/sequencer_checker.sv
tb/tb_top.sv
